### rtl/cbd_pkg.sv
// ----------------------------------------------------------------------------
// cbd_pkg: shared types for the circular buffer deque
// Operation and status codes, controller states and the request and
// response word layouts.
// ----------------------------------------------------------------------------
package cbd_pkg;

   typedef enum logic [1:0] {
      OP_PUSH_FRONT = 2'd0,
      OP_PUSH_REAR  = 2'd1,
      OP_POP_FRONT  = 2'd2,
      OP_POP_REAR   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE       = 2'd0,
      ST_FULL       = 2'd1,
      ST_EMPTY      = 2'd2,
      ST_RESERVED   = 2'd3
   } status_type;

   typedef enum logic {
      S_IDLE,
      S_FETCH
   } state_type;

   typedef struct packed {
      op_type             operation;
      logic signed [31:0] data_value;
   } req_word_type;

   typedef struct packed {
      status_type         status;
      logic signed [31:0] front_word;
      logic signed [31:0] rear_word;
      logic        [4:0]  occupancy;
      logic               empty_flag;
   } rsp_word_type;

endpackage

### rtl/circular_buffer_deque.sv
// ----------------------------------------------------------------------------
// circular_buffer_deque: double-ended queue of signed 32-bit words
// The response word is presented once the FETCH state has loaded it into the
// response register, or later while an earlier response word is still stalled.
// A new request is taken only in IDLE, not while FETCH reads the front and
// rear slots from the synchronous slot memory into the response register.
// Reset (synchronous, active high) empties the deque and clears all control
// state; slot contents are left as they are and are never read before written.
// ----------------------------------------------------------------------------
module circular_buffer_deque
   import cbd_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   // Index width, count width, and a count width padded so that the low five
   // bits can always be selected for the occupancy field.
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int EW = CW + 5;
   localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   // Controller state and deque bookkeeping.
   state_type       state_ff, state_in;
   logic [AW-1:0]   head_ff, head_in;
   logic [AW-1:0]   tail_ff, tail_in;
   logic            vacant_ff, vacant_in;
   logic [CW-1:0]   count_ff, count_in;
   status_type      status_ff, status_in;
   logic            rsp_valid_ff, rsp_valid_in;

   // The slot memory: one write port, two registered read ports.
   logic [31:0]     slot_mem [DEPTH];
   logic            wr_en;
   logic [AW-1:0]   wr_addr;

   logic            accept;
   logic            load;
   logic            is_push;
   logic [EW-1:0]   count_ext;
   rsp_word_type    rsp_ff;

   assign is_push   = (req_word.operation == OP_PUSH_FRONT) ||
                      (req_word.operation == OP_PUSH_REAR);
   assign count_ext = EW'(count_ff);

   // Controller: IDLE takes a request, FETCH reads the slots into the
   // response register as soon as that register is free or being emptied.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      load      = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            load = !rsp_valid_ff || !rsp_stall;
            if (load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign accept = req_valid && !req_stall;

   // Operation update: move one index (the last pop parks both on slot zero),
   // write at most one slot. A refused operation leaves indices and count alone.
   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      vacant_in = vacant_ff;
      count_in  = count_ff;
      status_in = status_ff;
      wr_en     = 1'b0;
      wr_addr   = head_ff;
      if (accept) begin
         status_in = ST_DONE;
         if (is_push) begin
            if (count_ff == FULL_COUNT) begin
               status_in = ST_FULL;
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + CW'(1);
               if (vacant_ff) begin
                  // First word lands in slot zero with both indices on it.
                  head_in   = '0;
                  tail_in   = '0;
                  vacant_in = 1'b0;
                  wr_addr   = '0;
               end else if (req_word.operation == OP_PUSH_FRONT) begin
                  head_in = (head_ff == '0) ? LAST_SLOT : head_ff - AW'(1);
                  wr_addr = head_in;
               end else begin
                  tail_in = (tail_ff == LAST_SLOT) ? '0 : tail_ff + AW'(1);
                  wr_addr = tail_in;
               end
            end
         end else begin
            if (vacant_ff) begin
               status_in = ST_EMPTY;
            end else begin
               count_in = count_ff - CW'(1);
               if (head_ff == tail_ff) begin
                  // Last word leaves: back to the reset arrangement.
                  vacant_in = 1'b1;
                  head_in   = '0;
                  tail_in   = '0;
               end else if (req_word.operation == OP_POP_FRONT) begin
                  head_in = (head_ff == LAST_SLOT) ? '0 : head_ff + AW'(1);
               end else begin
                  tail_in = (tail_ff == '0) ? LAST_SLOT : tail_ff - AW'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         tail_ff   <= '0;
         vacant_ff <= 1'b1;
         count_ff  <= '0;
         status_ff <= ST_DONE;
      end else begin
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         vacant_ff <= vacant_in;
         count_ff  <= count_in;
         status_ff <= status_in;
      end
   end

   // Slot memory write. The write lands at the accept edge, so the read in
   // the following FETCH cycle already sees it.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= req_word.data_value;
      end
   end

   // Registered reads go straight into the response register. An empty
   // deque reports zero for both end words.
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff.status     <= status_ff;
         rsp_ff.front_word <= vacant_ff ? '0 : slot_mem[head_ff];
         rsp_ff.rear_word  <= vacant_ff ? '0 : slot_mem[tail_ff];
         rsp_ff.occupancy  <= count_ext[4:0];
         rsp_ff.empty_flag <= vacant_ff;
      end
   end

   assign rsp_valid_in = load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // The empty mark and the count must always agree.
   a_vacant_count: assert property (@(posedge clock) disable iff (reset)
      vacant_ff == (count_ff == '0))
      else $error("empty mark disagrees with word count");

   // The count never exceeds the store depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("word count above depth");

   // An empty deque keeps both indices parked on slot zero.
   a_vacant_park: assert property (@(posedge clock) disable iff (reset)
      vacant_ff |-> (head_ff == '0) && (tail_ff == '0))
      else $error("indices not parked while empty");

   // A refused operation leaves the count untouched.
   a_refused_stable: assert property (@(posedge clock) disable iff (reset)
      accept && ((is_push && count_ff == FULL_COUNT) || (!is_push && vacant_ff))
      |=> $stable(count_ff) && $stable(head_ff) && $stable(tail_ff))
      else $error("refused operation changed the deque");

endmodule

### dv/cbd_checker.sv
// ----------------------------------------------------------------------------
// cbd_checker: response predictor and comparator for the circular buffer deque
// Watches both channels, keeps its own copy of the deque, predicts the
// response word for every accepted request word and compares it field by
// field with the oldest prediction when a response word is accepted.
// ----------------------------------------------------------------------------
module cbd_checker
   import cbd_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_stall,
   input  req_word_type req_word,
   input  logic         rsp_valid,
   input  logic         rsp_stall,
   input  rsp_word_type rsp_word,
   output int           mismatch_count,
   output int           words_outstanding
);

   timeunit 1ns;
   timeprecision 1ps;

   // Shadow copy of the deque.
   logic signed [31:0] slot_copy [DEPTH];
   int                 front_slot;
   int                 rear_slot;
   bit                 deque_vacant;

   rsp_word_type       predicted_words [$];
   int                 error_total = 0;
   int                 waiting_total = 0;
   int                 responses_seen = 0;

   assign mismatch_count    = error_total;
   assign words_outstanding = waiting_total;

   function automatic int held_words();
      if (deque_vacant) begin
         return 0;
      end
      return (rear_slot + DEPTH - front_slot) % DEPTH + 1;
   endfunction

   // Applies one operation to the shadow deque and returns the response word.
   function automatic rsp_word_type apply_operation(input req_word_type w);
      rsp_word_type r;
      int           count;
      r.status = ST_DONE;
      if (w.operation == OP_PUSH_FRONT || w.operation == OP_PUSH_REAR) begin
         if (held_words() >= DEPTH) begin
            r.status = ST_FULL;
         end else if (deque_vacant) begin
            front_slot    = 0;
            rear_slot     = 0;
            deque_vacant  = 1'b0;
            slot_copy[0]  = w.data_value;
         end else if (w.operation == OP_PUSH_FRONT) begin
            front_slot            = (front_slot + DEPTH - 1) % DEPTH;
            slot_copy[front_slot] = w.data_value;
         end else begin
            rear_slot            = (rear_slot + 1) % DEPTH;
            slot_copy[rear_slot] = w.data_value;
         end
      end else begin
         if (deque_vacant) begin
            r.status = ST_EMPTY;
         end else if (front_slot == rear_slot) begin
            // The last word leaves; both indices return to slot zero.
            deque_vacant = 1'b1;
            front_slot   = 0;
            rear_slot    = 0;
         end else if (w.operation == OP_POP_FRONT) begin
            front_slot = (front_slot + 1) % DEPTH;
         end else begin
            rear_slot = (rear_slot + DEPTH - 1) % DEPTH;
         end
      end
      count        = held_words();
      r.front_word = deque_vacant ? '0 : slot_copy[front_slot];
      r.rear_word  = deque_vacant ? '0 : slot_copy[rear_slot];
      r.occupancy  = count[4:0];
      r.empty_flag = deque_vacant;
      return r;
   endfunction

   task automatic report_mismatch(input string field_name, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: response word %0d: %s is %0h, expected %0h",
               $realtime, responses_seen, field_name, got, want);
      error_total++;
   endtask

   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         front_slot   = 0;
         rear_slot    = 0;
         deque_vacant = 1'b1;
         predicted_words.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (predicted_words.size() == 0) begin
               report_mismatch("unexpected response word", '0, '0);
            end else begin
               want = predicted_words.pop_front();
               if (rsp_word.status !== want.status)
                  report_mismatch("status", 32'(rsp_word.status), 32'(want.status));
               if (rsp_word.front_word !== want.front_word)
                  report_mismatch("front_word", rsp_word.front_word, want.front_word);
               if (rsp_word.rear_word !== want.rear_word)
                  report_mismatch("rear_word", rsp_word.rear_word, want.rear_word);
               if (rsp_word.occupancy !== want.occupancy)
                  report_mismatch("occupancy", 32'(rsp_word.occupancy),
                                  32'(want.occupancy));
               if (rsp_word.empty_flag !== want.empty_flag)
                  report_mismatch("empty_flag", 32'(rsp_word.empty_flag),
                                  32'(want.empty_flag));
            end
            responses_seen++;
         end
         if (req_valid && !req_stall) begin
            predicted_words.push_back(apply_operation(req_word));
         end
      end
      waiting_total = predicted_words.size();
   end

endmodule

### dv/tb_circular_buffer_deque.sv
// ----------------------------------------------------------------------------
// tb_circular_buffer_deque: testbench top for the circular buffer deque
// Drives a directed opening sequence and then biased random operation words
// with bursty request traffic and a randomly stalling receiver, including one
// long receiver hold-off. A checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_circular_buffer_deque
   import cbd_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS            = 16;
   localparam int RANDOM_WORDS     = 550;
   localparam int CYCLE_LIMIT      = 200000;
   // The receiver holds off once, long enough for the block to back up and
   // stall the request channel while the sender keeps offering words.
   localparam int HOLD_START_CYCLE = 400;
   localparam int HOLD_CYCLES      = 250;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   int           mismatch_count;
   int           words_outstanding;
   int           cycle_count = 0;
   int           burst_left  = 4;

   always #5 clock = ~clock;

   circular_buffer_deque #(
      .DEPTH(SLOTS)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_word (req_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word (rsp_word)
   );

   cbd_checker #(
      .DEPTH(SLOTS)
   ) i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_word         (req_word),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_word         (rsp_word),
      .mismatch_count   (mismatch_count),
      .words_outstanding(words_outstanding)
   );

   // A run that hangs is a failure; the limit is far above the slowest
   // correct run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Data values lean on the extremes of the signed range now and then, so
   // the sign bit and all-ones and all-zeros patterns travel through often.
   function automatic logic signed [31:0] pick_data();
      case ($urandom_range(0, 9))
         0: begin
            return 32'sh7fffffff;
         end
         1: begin
            return 32'sh80000000;
         end
         2: begin
            return '0;
         end
         3: begin
            return '1;
         end
         default: begin
            return $urandom();
         end
      endcase
   endfunction

   // Offers one request word and holds it until the block takes it. The
   // sender works in bursts; when a burst runs out, valid drops for a random
   // gap (sometimes none, so long unbroken stretches also occur).
   task automatic send_op(input op_type op, input logic signed [31:0] value);
      req_word_type w;
      int           gap;
      w.operation  = op;
      w.data_value = value;
      req_word  <= w;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   // Receiver: a stall pattern of its own that switches between no stalls,
   // light, medium and heavy stalling, plus the one long hold-off.
   initial begin
      int stall_percent;
      int mode_left;
      int cycle_no;
      stall_percent = 0;
      mode_left     = 0;
      cycle_no      = 0;
      @(negedge clock);
      forever begin
         if (mode_left == 0) begin
            case ($urandom_range(0, 4))
               0, 1: begin
                  stall_percent = 0;
               end
               2: begin
                  stall_percent = 20;
               end
               3: begin
                  stall_percent = 50;
               end
               default: begin
                  stall_percent = 80;
               end
            endcase
            mode_left = $urandom_range(10, 60);
         end
         if (cycle_no >= HOLD_START_CYCLE && cycle_no < HOLD_START_CYCLE + HOLD_CYCLES) begin
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(1, 100) <= stall_percent);
         end
         mode_left--;
         cycle_no++;
         @(negedge clock);
      end
   end

   // Stimulus and verdict.
   initial begin
      int push_percent;
      int mode_left;
      push_percent = 50;
      mode_left    = 0;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed opening. Pops on an empty deque are refused at both ends.
      send_op(OP_POP_FRONT, 32'sh5a5a5a5a);
      send_op(OP_POP_REAR, 32'sha5a5a5a5);
      // A push into the empty deque lands in slot zero; a front push then
      // wraps the head index down to the top slot.
      send_op(OP_PUSH_REAR, 32'sh7fffffff);
      send_op(OP_PUSH_FRONT, 32'sh80000000);
      // The tail sits in slot zero here, so a rear pop must wrap it to the
      // top slot rather than stick.
      send_op(OP_POP_REAR, '0);
      // Popping the last word empties the deque and returns both indices
      // to slot zero.
      send_op(OP_POP_FRONT, '1);
      send_op(OP_PUSH_FRONT, '0);
      send_op(OP_PUSH_REAR, '1);
      // Fill to capacity from both ends with extreme and random data.
      for (int n = 0; n < SLOTS - 2; n++) begin
         send_op((n % 2 == 0) ? OP_PUSH_FRONT : OP_PUSH_REAR,
                 (n < 4) ? pick_data() : $urandom());
      end
      // A full deque refuses pushes at both ends and stays unchanged.
      send_op(OP_PUSH_FRONT, 32'sh12345678);
      send_op(OP_PUSH_REAR, 32'shedcba987);
      send_op(OP_POP_FRONT, '0);
      send_op(OP_POP_REAR, '0);

      // Random part: operations come in stretches biased toward filling,
      // toward draining, or balanced, so the occupancy walks between empty
      // and full many times and refusals occur at both limits.
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (mode_left == 0) begin
            case ($urandom_range(0, 2))
               0: begin
                  push_percent = 80;
               end
               1: begin
                  push_percent = 20;
               end
               default: begin
                  push_percent = 50;
               end
            endcase
            mode_left = $urandom_range(8, 40);
         end
         mode_left--;
         if ($urandom_range(1, 100) <= push_percent) begin
            send_op(($urandom_range(0, 1) == 0) ? OP_PUSH_FRONT : OP_PUSH_REAR, pick_data());
         end else begin
            send_op(($urandom_range(0, 1) == 0) ? OP_POP_FRONT : OP_POP_REAR, pick_data());
         end
      end
      req_valid <= 1'b0;

      // Let every predicted response word arrive, then a few quiet cycles
      // to catch any stray response word.
      while (words_outstanding != 0) @(negedge clock);
      repeat (8) @(negedge clock);

      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

### circular_buffer_deque.f
rtl/cbd_pkg.sv
rtl/circular_buffer_deque.sv
dv/cbd_checker.sv
dv/tb_circular_buffer_deque.sv
